// ===== rtl/core/lsc_pkg.sv =====
package lsc_pkg;

  // Sensor arrangement.
  localparam int FRONT_SENSORS    = 9;
  localparam int POSITION_SENSORS = 5;
  localparam int CHANNELS         = FRONT_SENSORS + 3;
  localparam int REAR_LEFT        = FRONT_SENSORS;
  localparam int REAR_RIGHT       = FRONT_SENSORS + 1;
  localparam int LAST_CH          = CHANNELS - 1;
  localparam int CENTER_BIT       = FRONT_SENSORS / 2;
  localparam int WINDOW_START     = (FRONT_SENSORS - POSITION_SENSORS) / 2;

  // Field widths.
  localparam int OP_W     = 3;
  localparam int CH_W     = 4;
  localparam int RD_W     = 10;
  localparam int PIN_W    = 2;
  localparam int MASK_W   = FRONT_SENSORS;
  localparam int COUNT_W  = $clog2(FRONT_SENSORS + 1);
  localparam int POS_W    = 12;
  localparam int PAIR_W   = 2;
  localparam int CH_IDX_W = $clog2(CHANNELS);

  localparam int FULL_SCALE  = 1023;
  localparam int STEP_WEIGHT = 1000;
  localparam int CENTER_POS  = (POSITION_SENSORS - 1) * STEP_WEIGHT / 2;

  // Position divider sizing.
  localparam int SUM_MAX    = STEP_WEIGHT * POSITION_SENSORS * (POSITION_SENSORS - 1) / 2;
  localparam int SUM_W      = (SUM_MAX > 0) ? $clog2(SUM_MAX + 1) : 1;
  localparam int N_W        = $clog2(POSITION_SENSORS + 1);
  localparam int STEP_CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_WHITE   = 3'd1,
    OP_BLACK   = 3'd2,
    OP_THRESH  = 3'd3,
    OP_MEASURE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_THRESH,
    ST_DIVIDE,
    ST_DELIVER
  } back_state_t;

  typedef struct packed {
    op_t                 op;
    logic [CH_IDX_W-1:0] ch;
    logic [RD_W-1:0]     reading;
    logic [PIN_W-1:0]    pins;
  } cmd_t;

endpackage

// ===== rtl/core/lsc_if.sv =====
interface lsc_sample_if import lsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [CH_W-1:0]  channel;
  logic [RD_W-1:0]  raw_sample;
  logic [PIN_W-1:0] center_pins;

  modport source (output valid, operation, channel, raw_sample, center_pins, input ready);
  modport sink   (input valid, operation, channel, raw_sample, center_pins, output ready);
endinterface

interface lsc_result_if import lsc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  front_mask;
  logic [COUNT_W-1:0] on_line_count;
  logic [POS_W-1:0]   line_position;
  logic [PAIR_W-1:0]  rear_pair;
  logic               rear_center;
  logic               center_analog;

  modport source (output valid, front_mask, on_line_count, line_position, rear_pair,
                  rear_center, center_analog, input ready);
  modport sink   (input valid, front_mask, on_line_count, line_position, rear_pair,
                  rear_center, center_analog, output ready);
endinterface

// ===== rtl/core/lsc_front.sv =====
module lsc_front import lsc_pkg::*; (
  lsc_sample_if.sink samples,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam logic [RD_W-1:0] FULL_SCALE_V = RD_W'(FULL_SCALE);

  logic keep;

  // Items that have no effect (unused codes, channels past the rear center)
  // are taken and dropped here so the back end never sees them.
  always_comb begin
    keep = 1'b0;
    unique case (samples.operation)
      OP_CLEAR, OP_THRESH:             keep = 1'b1;
      OP_WHITE, OP_BLACK, OP_MEASURE:  keep = (samples.channel < CH_W'(CHANNELS));
      default:                         keep = 1'b0;
    endcase
  end

  assign samples.ready    = !queue_full;
  assign push             = samples.valid && !queue_full && keep;
  assign push_cmd.op      = op_t'(samples.operation);
  assign push_cmd.ch      = CH_IDX_W'(samples.channel);
  assign push_cmd.reading = FULL_SCALE_V - samples.raw_sample;
  assign push_cmd.pins    = samples.center_pins;

endmodule

// ===== rtl/core/lsc_fifo.sv =====
module lsc_fifo import lsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/lsc_back.sv =====
module lsc_back import lsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  lsc_result_if.source results
);

  localparam logic [CH_IDX_W-1:0]   FRONT_V      = CH_IDX_W'(FRONT_SENSORS);
  localparam logic [CH_IDX_W-1:0]   FRONT_LAST_V = CH_IDX_W'(FRONT_SENSORS - 1);
  localparam logic [CH_IDX_W-1:0]   REAR_LEFT_V  = CH_IDX_W'(REAR_LEFT);
  localparam logic [CH_IDX_W-1:0]   REAR_RIGHT_V = CH_IDX_W'(REAR_RIGHT);
  localparam logic [CH_IDX_W-1:0]   LAST_CH_V    = CH_IDX_W'(LAST_CH);
  localparam logic [STEP_CNT_W-1:0] LAST_STEP_V  = STEP_CNT_W'(SUM_W - 1);

  back_state_t state, state_next;

  logic white_line_mode;

  logic [RD_W-1:0] white_high [CHANNELS];
  logic [RD_W-1:0] white_low  [CHANNELS];
  logic [RD_W-1:0] black_high [CHANNELS];
  logic [RD_W-1:0] black_low  [CHANNELS];
  logic [RD_W-1:0] threshold  [CHANNELS];

  logic [MASK_W-1:0]  mask_accum;
  logic [COUNT_W-1:0] count_accum;
  logic [PAIR_W-1:0]  rear_accum;
  logic               white_first_frame;
  logic               black_first_frame;

  logic [CH_IDX_W-1:0]   idx;
  logic [STEP_CNT_W-1:0] step;

  // Frame result waiting for its position.
  logic [MASK_W-1:0]  pend_mask;
  logic [COUNT_W-1:0] pend_count;
  logic [PAIR_W-1:0]  pend_pair;
  logic               pend_rc;
  logic               pend_canalog;
  logic [N_W-1:0]     pend_n;
  logic [SUM_W-1:0]   dvd;
  logic [N_W-1:0]     rem;

  // Output register.
  logic               out_valid;
  logic [MASK_W-1:0]  out_mask;
  logic [COUNT_W-1:0] out_count;
  logic [POS_W-1:0]   out_pos;
  logic [PAIR_W-1:0]  out_pair;
  logic               out_rc;
  logic               out_canalog;

  logic [CH_IDX_W-1:0] rd_addr;
  logic [RD_W-1:0]     rd;
  logic [RD_W-1:0]     thr_sel;
  logic [CH_IDX_W-1:0] fidx;
  logic [RD_W:0]       thr_sum;

  logic [MASK_W-1:0]  fin_mask;
  logic [COUNT_W-1:0] fin_count;
  logic [PAIR_W-1:0]  fin_pair;
  logic               fin_rc;
  logic               any_low;
  logic [SUM_W-1:0]   fin_sum;
  logic [N_W-1:0]     fin_n;

  logic [N_W:0]   trial;
  logic           q_bit;
  logic [N_W-1:0] rem_next;
  logic           out_free;

  // One read address serves both the threshold sweep and the item at the head.
  assign rd_addr = (state == ST_THRESH) ? idx : head_cmd.ch;
  assign rd      = head_cmd.reading;
  assign thr_sel = threshold[rd_addr];
  assign fidx    = FRONT_LAST_V - head_cmd.ch;
  assign thr_sum = (rd_addr < FRONT_V) ?
                   ({1'b0, white_low[rd_addr]} + {1'b0, black_high[rd_addr]}) :
                   ({1'b0, white_high[rd_addr]} + {1'b0, black_low[rd_addr]});

  // Frame-ending item: polarity, center pins and the position window sum.
  always_comb begin
    any_low   = (head_cmd.pins != '1);
    fin_mask  = mask_accum;
    fin_count = count_accum;
    fin_pair  = rear_accum;
    fin_rc    = (rd < thr_sel);
    if (white_line_mode) begin
      if (any_low) fin_mask[CENTER_BIT] = 1'b1;
      fin_mask = ~fin_mask;
      if (any_low) fin_mask[CENTER_BIT] = 1'b1;
      fin_count = COUNT_W'(FRONT_SENSORS) - count_accum;
      fin_pair  = ~rear_accum;
      fin_rc    = ~fin_rc;
    end else if (head_cmd.pins != '0) begin
      fin_mask[CENTER_BIT] = 1'b1;
    end
    fin_sum = '0;
    fin_n   = '0;
    for (int j = 0; j < POSITION_SENSORS; j++) begin
      if (fin_mask[FRONT_SENSORS - 1 - WINDOW_START - j]) begin
        fin_sum = fin_sum + SUM_W'(j * STEP_WEIGHT);
        fin_n   = fin_n + N_W'(1);
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign trial    = {rem, dvd[SUM_W-1]};
  assign q_bit    = (trial >= {1'b0, pend_n});
  assign rem_next = q_bit ? N_W'(trial - {1'b0, pend_n}) : trial[N_W-1:0];
  assign out_free = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head_cmd.op == OP_THRESH) begin
            state_next = ST_THRESH;
          end else if (head_cmd.op == OP_MEASURE && head_cmd.ch == LAST_CH_V) begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_THRESH: begin
        if (idx == LAST_CH_V) state_next = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (step == LAST_STEP_V) state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      white_line_mode   <= 1'b0;
      out_valid         <= 1'b0;
      mask_accum        <= '0;
      count_accum       <= '0;
      rear_accum        <= '0;
      white_first_frame <= 1'b1;
      black_first_frame <= 1'b1;
      idx               <= '0;
      step              <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        white_high[k] <= '0;
        white_low[k]  <= '0;
        black_high[k] <= '0;
        black_low[k]  <= '0;
        threshold[k]  <= '0;
      end
    end else begin
      if (cfg_write_en) white_line_mode <= cfg_write_data;
      // The deliver state reloads the output register itself.
      if (results.ready && state != ST_DELIVER) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (head_valid) begin
            unique case (head_cmd.op)
              OP_CLEAR: begin
                for (int k = 0; k < CHANNELS; k++) begin
                  white_high[k] <= '0;
                  white_low[k]  <= '0;
                  black_high[k] <= '0;
                  black_low[k]  <= '0;
                  threshold[k]  <= '0;
                end
                mask_accum        <= '0;
                count_accum       <= '0;
                rear_accum        <= '0;
                white_first_frame <= 1'b1;
                black_first_frame <= 1'b1;
              end
              OP_WHITE: begin
                if (rd > white_high[rd_addr]) white_high[rd_addr] <= rd;
                if (white_first_frame || rd < white_low[rd_addr]) white_low[rd_addr] <= rd;
                if (head_cmd.ch == LAST_CH_V) white_first_frame <= 1'b0;
              end
              OP_BLACK: begin
                if (rd > black_high[rd_addr]) black_high[rd_addr] <= rd;
                if (black_first_frame || rd < black_low[rd_addr]) black_low[rd_addr] <= rd;
                if (head_cmd.ch == LAST_CH_V) black_first_frame <= 1'b0;
              end
              OP_THRESH: begin
                idx <= '0;
              end
              OP_MEASURE: begin
                if (head_cmd.ch < FRONT_V) begin
                  // A front sensor counts once per frame.
                  if (rd > thr_sel && !mask_accum[fidx]) begin
                    mask_accum[fidx] <= 1'b1;
                    count_accum      <= count_accum + COUNT_W'(1);
                  end
                end else if (head_cmd.ch == REAR_LEFT_V) begin
                  if (rd < thr_sel) rear_accum[1] <= 1'b1;
                end else if (head_cmd.ch == REAR_RIGHT_V) begin
                  if (rd < thr_sel) rear_accum[0] <= 1'b1;
                end else begin
                  pend_mask    <= fin_mask;
                  pend_count   <= fin_count;
                  pend_pair    <= fin_pair;
                  pend_rc      <= fin_rc;
                  pend_canalog <= mask_accum[CENTER_BIT];
                  pend_n       <= fin_n;
                  dvd          <= fin_sum;
                  rem          <= '0;
                  step         <= '0;
                  mask_accum   <= '0;
                  count_accum  <= '0;
                  rear_accum   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_THRESH: begin
          threshold[idx] <= thr_sum[RD_W:1];
          idx            <= idx + CH_IDX_W'(1);
        end
        ST_DIVIDE: begin
          dvd  <= SUM_W'({dvd, q_bit});
          rem  <= rem_next;
          step <= step + STEP_CNT_W'(1);
        end
        ST_DELIVER: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_mask    <= pend_mask;
            out_count   <= pend_count;
            out_pos     <= (pend_n == '0) ? POS_W'(CENTER_POS) : POS_W'(dvd);
            out_pair    <= pend_pair;
            out_rc      <= pend_rc;
            out_canalog <= pend_canalog;
          end
        end
        default: ;
      endcase
    end
  end

  assign results.valid         = out_valid;
  assign results.front_mask    = out_mask;
  assign results.on_line_count = out_count;
  assign results.line_position = out_pos;
  assign results.rear_pair     = out_pair;
  assign results.rear_center   = out_rc;
  assign results.center_analog = out_canalog;

endmodule

// ===== rtl/core/line_sensor_calibrate_and_locate_top.sv =====
// Line sensor calibration and locator.
// The samples channel takes one item per converter sample: an operation code
// (clear, white sample, black sample, compute thresholds, measure), a channel
// index, the raw sample and the two center pin levels. The results channel
// carries one item per measure frame, when the rear center channel arrives.
// cfg_write_en/cfg_write_data set white-line mode; the user must do so only
// while the block is idle, since the block itself does not enforce this.
// Items enter a short queue at up to one per cycle; ready drops only when the
// queue is full. Compute thresholds walks all channels through the calibration
// registers at one channel per cycle, holding the back end until it is done.
// The frame-ending measure item runs a bit-serial position divider, then waits
// for a free output register before it appears on the results channel.
// Reset clears all calibration values, thresholds and frame state, arms both
// calibration passes for a first frame and selects dark-line mode.
// When the receiver stalls the result stays in the output register; the back
// end keeps working until the next frame result needs that register.
module line_sensor_calibrate_and_locate_top import lsc_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic         cfg_write_data,
  lsc_sample_if.sink   samples,
  lsc_result_if.source results
);

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  lsc_front u_front (
    .samples    (samples),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lsc_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .results        (results)
  );

endmodule

// ===== test/tb_line_sensor_calibrate_and_locate_top.sv =====
`timescale 1ns / 1ps

module tb_line_sensor_calibrate_and_locate_top;
  import lsc_pkg::*;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_PHASE = 3;
  localparam int SAMPLE_TARGET  = 750;
  localparam int FRAME_TARGET   = 36;
  localparam int WHITE_CAL      = 0;
  localparam int BLACK_CAL      = 1;

  // Operation codes that the block does not define.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef logic [RD_W-1:0] reading_t;

  typedef struct packed {
    logic [MASK_W-1:0]  front_mask;
    logic [COUNT_W-1:0] on_line_count;
    logic [POS_W-1:0]   line_position;
    logic [PAIR_W-1:0]  rear_pair;
    logic               rear_center;
    logic               center_analog;
  } frame_result_t;

  class line_frame_checker;
    reading_t           cal_high[2][CHANNELS];
    reading_t           cal_low[2][CHANNELS];
    bit                 cal_first[2];
    reading_t           thresh[CHANNELS];
    logic [MASK_W-1:0]  frame_mask;
    logic [COUNT_W-1:0] frame_count;
    logic [PAIR_W-1:0]  frame_rear;
    bit                 white_line;
    frame_result_t      expected_frames[$];
    int                 mismatch_count;
    int                 live_samples;
    int                 frames_predicted;

    function new();
      white_line       = 1'b0;
      mismatch_count   = 0;
      live_samples     = 0;
      frames_predicted = 0;
      clear_calibration();
    endfunction

    function void clear_calibration();
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < 2; k++) begin
          cal_high[k][c] = '0;
          cal_low[k][c]  = '0;
        end
        thresh[c] = '0;
      end
      cal_first[WHITE_CAL] = 1'b1;
      cal_first[BLACK_CAL] = 1'b1;
      frame_mask  = '0;
      frame_count = '0;
      frame_rear  = '0;
    endfunction

    function void set_mode(bit mode);
      white_line = mode;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function void close_frame(reading_t rd, logic [PIN_W-1:0] pins);
      frame_result_t      r;
      logic [MASK_W-1:0]  mask;
      logic [COUNT_W-1:0] count;
      logic [PAIR_W-1:0]  pair;
      logic               rc;
      bit                 any_low;
      int                 sum;
      int                 n;
      rc    = (rd < thresh[LAST_CH]);
      mask  = frame_mask;
      count = frame_count;
      pair  = frame_rear;
      r.center_analog = mask[CENTER_BIT];
      if (white_line) begin
        // A low pin marks the center both before and after the inversion.
        any_low = (pins != '1);
        if (any_low) mask[CENTER_BIT] = 1'b1;
        mask = ~mask;
        if (any_low) mask[CENTER_BIT] = 1'b1;
        count = COUNT_W'(FRONT_SENSORS - int'(count));
        pair  = ~pair;
        rc    = ~rc;
      end else if (pins != '0) begin
        mask[CENTER_BIT] = 1'b1;
      end
      sum = 0;
      n   = 0;
      for (int j = 0; j < POSITION_SENSORS; j++) begin
        if (mask[FRONT_SENSORS - 1 - (WINDOW_START + j)]) begin
          sum += j * STEP_WEIGHT;
          n++;
        end
      end
      r.front_mask    = mask;
      r.on_line_count = count;
      r.line_position = POS_W'((n > 0) ? sum / n : CENTER_POS);
      r.rear_pair     = pair;
      r.rear_center   = rc;
      expected_frames.push_back(r);
      frames_predicted++;
      frame_mask  = '0;
      frame_count = '0;
      frame_rear  = '0;
    endfunction

    function void note_sample(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                              logic [RD_W-1:0] raw, logic [PIN_W-1:0] pins);
      reading_t rd;
      int       cal;
      rd = RD_W'(FULL_SCALE - int'(raw));
      if (op == OP_CLEAR) begin
        clear_calibration();
        live_samples++;
      end else if (op == OP_THRESH) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (c < FRONT_SENSORS)
            thresh[c] = RD_W'((int'(cal_low[WHITE_CAL][c]) + int'(cal_high[BLACK_CAL][c])) / 2);
          else
            thresh[c] = RD_W'((int'(cal_high[WHITE_CAL][c]) + int'(cal_low[BLACK_CAL][c])) / 2);
        end
        live_samples++;
      end else if (ch < CHANNELS && (op == OP_WHITE || op == OP_BLACK)) begin
        cal = (op == OP_WHITE) ? WHITE_CAL : BLACK_CAL;
        if (rd > cal_high[cal][ch]) cal_high[cal][ch] = rd;
        if (cal_first[cal] || rd < cal_low[cal][ch]) cal_low[cal][ch] = rd;
        if (ch == LAST_CH) cal_first[cal] = 1'b0;
        live_samples++;
      end else if (ch < CHANNELS && op == OP_MEASURE) begin
        live_samples++;
        if (ch < FRONT_SENSORS) begin
          // A front sensor seen twice in one frame is counted once.
          if (rd > thresh[ch] && !frame_mask[FRONT_SENSORS - 1 - ch]) begin
            frame_mask[FRONT_SENSORS - 1 - ch] = 1'b1;
            frame_count++;
          end
        end else if (ch == REAR_LEFT) begin
          if (rd < thresh[ch]) frame_rear[1] = 1'b1;
        end else if (ch == REAR_RIGHT) begin
          if (rd < thresh[ch]) frame_rear[0] = 1'b1;
        end else begin
          close_frame(rd, pins);
        end
      end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mask %b count %0d pos %0d",
                 $time, got.front_mask, got.on_line_count, got.line_position);
        mismatch_count++;
        return;
      end
      want = expected_frames.pop_front();
      compare_field("front_mask", want.front_mask, got.front_mask);
      compare_field("on_line_count", want.on_line_count, got.on_line_count);
      compare_field("line_position", want.line_position, got.line_position);
      compare_field("rear_pair", want.rear_pair, got.rear_pair);
      compare_field("rear_center", want.rear_center, got.rear_center);
      compare_field("center_analog", want.center_analog, got.center_analog);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  lsc_sample_if samples();
  lsc_result_if results();

  line_sensor_calibrate_and_locate_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .samples        (samples),
    .results        (results)
  );

  line_frame_checker sb;
  bit send_steady;
  bit rx_steady;
  bit hold_request;
  int white_lo, white_hi, black_lo, black_hi;
  int cycle_count;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("line_sensor_calibrate_and_locate_top test failed");
    $finish;
  end

  // Result receiver: random stalls per item, plus one long hold-off on request.
  initial begin
    int stall;
    results.ready <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          results.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        results.ready <= 1'b1;
        @(posedge clk);
        while (!results.valid && !hold_request) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results.valid === 1'b1 && results.ready === 1'b1)
      sb.check_frame(frame_result_t'{results.front_mask, results.on_line_count,
                                     results.line_position, results.rear_pair,
                                     results.rear_center, results.center_analog});
  end

  // Leaves valid high on return, so the next call or settle task sets it once.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [RD_W-1:0] raw, input logic [PIN_W-1:0] pins);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid       <= 1'b1;
    samples.operation   <= op;
    samples.channel     <= ch;
    samples.raw_sample  <= raw;
    samples.center_pins <= pins;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    sb.note_sample(op, ch, raw, pins);
  endtask

  function automatic logic [RD_W-1:0] pick_raw(logic [OP_W-1:0] op);
    int choice;
    choice = $urandom_range(0, 2);
    if (op == OP_WHITE || (op == OP_MEASURE && choice == 0))
      return RD_W'($urandom_range(white_hi, white_lo));
    else if (op == OP_BLACK || choice == 1)
      return RD_W'($urandom_range(black_hi, black_lo));
    return RD_W'($urandom_range(FULL_SCALE, 0));
  endfunction

  // One pass over all channels; a broken frame skips, repeats or strays.
  task automatic send_frame(input logic [OP_W-1:0] op, input bit broken);
    for (int c = 0; c < CHANNELS; c++) begin
      if (!(broken && $urandom_range(0, 5) == 0))
        send_item(op, CH_W'(c), pick_raw(op), PIN_W'($urandom_range(0, 3)));
      if (broken && $urandom_range(0, 4) == 0)
        send_item(op, CH_W'($urandom_range(0, 15)), pick_raw(op),
                  PIN_W'($urandom_range(0, 3)));
    end
  endtask

  task automatic settle_and_configure(input bit mode);
    samples.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Ignored items and threshold passes may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mode;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_mode(mode);
  endtask

  task automatic run_episode();
    white_lo = $urandom_range(0, 600);
    white_hi = white_lo + $urandom_range(0, 423);
    black_lo = $urandom_range(0, 600);
    black_hi = black_lo + $urandom_range(0, 423);
    if ($urandom_range(0, 3) != 0)
      send_item(OP_CLEAR, CH_W'($urandom_range(0, 15)), RD_W'($urandom_range(0, 1023)),
                PIN_W'($urandom_range(0, 3)));
    repeat ($urandom_range(1, 3)) send_frame(OP_WHITE, $urandom_range(0, 7) == 0);
    repeat ($urandom_range(1, 3)) send_frame(OP_BLACK, $urandom_range(0, 7) == 0);
    send_item(OP_THRESH, CH_W'($urandom_range(0, 15)), RD_W'($urandom_range(0, 1023)),
              PIN_W'($urandom_range(0, 3)));
    repeat ($urandom_range(3, 6)) send_frame(OP_MEASURE, $urandom_range(0, 4) == 0);
    repeat ($urandom_range(0, 4))
      send_item(OP_W'($urandom_range(0, 7)), CH_W'($urandom_range(0, 15)),
                RD_W'($urandom_range(0, 1023)), PIN_W'($urandom_range(0, 3)));
  endtask

  initial begin
    int phase;
    sb = new();
    send_steady  = 1'b0;
    rx_steady    = 1'b0;
    hold_request = 1'b0;
    white_lo = 0;
    white_hi = FULL_SCALE;
    black_lo = 0;
    black_hi = FULL_SCALE;
    rst                 <= 1'b1;
    cfg_write_en        <= 1'b0;
    cfg_write_data      <= 1'b0;
    samples.valid       <= 1'b0;
    samples.operation   <= OP_CLEAR;
    samples.channel     <= '0;
    samples.raw_sample  <= '0;
    samples.center_pins <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, dark-line mode from reset.
    send_item(OP_SPARE_A, CH_W'(0), RD_W'(0), PIN_W'(0));
    send_item(OP_SPARE_B, CH_W'(5), RD_W'(512), PIN_W'(1));
    send_item(OP_SPARE_C, CH_W'(15), RD_W'(1023), PIN_W'(3));
    send_item(OP_WHITE, CH_W'(12), RD_W'(512), PIN_W'(2));
    send_item(OP_MEASURE, CH_W'(15), RD_W'(0), PIN_W'(3));
    send_item(OP_WHITE, CH_W'(LAST_CH), RD_W'(1023), PIN_W'(0));
    send_item(OP_BLACK, CH_W'(0), RD_W'(0), PIN_W'(0));
    send_item(OP_THRESH, CH_W'(15), RD_W'(1023), PIN_W'(3));
    send_item(OP_MEASURE, CH_W'(0), RD_W'(0), PIN_W'(0));
    send_item(OP_MEASURE, CH_W'(0), RD_W'(0), PIN_W'(0));
    send_item(OP_MEASURE, CH_W'(1), RD_W'(1023), PIN_W'(0));
    send_item(OP_MEASURE, CH_W'(CENTER_BIT), RD_W'(0), PIN_W'(0));
    send_item(OP_MEASURE, CH_W'(REAR_LEFT), RD_W'(0), PIN_W'(0));
    send_item(OP_MEASURE, CH_W'(REAR_RIGHT), RD_W'(1023), PIN_W'(0));
    send_item(OP_MEASURE, CH_W'(LAST_CH), RD_W'(1023), PIN_W'(3));
    send_item(OP_MEASURE, CH_W'(LAST_CH), RD_W'(0), PIN_W'(0));
    send_item(OP_CLEAR, CH_W'(0), RD_W'(0), PIN_W'(0));
    send_item(OP_MEASURE, CH_W'(LAST_CH), RD_W'(1023), PIN_W'(1));

    // Random phases alternate white-line and dark-line mode.
    phase = 0;
    while (sb.live_samples < SAMPLE_TARGET || sb.frames_predicted < FRAME_TARGET) begin
      settle_and_configure(!phase[0]);
      send_steady = ($urandom_range(0, 3) == 0);
      rx_steady   = ($urandom_range(0, 3) == 0);
      if (phase == PRESSURE_PHASE) begin
        // Back-to-back frames against a stalled receiver fill the block.
        hold_request = 1'b1;
        send_steady  = 1'b1;
        repeat (4) send_frame(OP_MEASURE, 1'b0);
        send_steady  = 1'b0;
      end
      run_episode();
      phase++;
    end

    samples.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0)
      $display("line_sensor_calibrate_and_locate_top test passed");
    else
      $display("line_sensor_calibrate_and_locate_top test failed");
    $finish;
  end

endmodule
